>>> design/mtt_pkg.sv
// ----------------------------------------------------------------------------
// mtt_pkg: shared types and codes of the timer table
// Entry layout, operation and result codes, and the structs that pass
// between the sequencer and the entry unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mtt_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_DROP  = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  // Timer modes; the fourth code marks a disposed entry
  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_CHAIN  = 2'd1;
  localparam logic [1:0] MODE_REPEAT = 2'd2;
  localparam logic [1:0] MODE_GONE   = 2'd3;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_DONE   = 3'd0,
    KIND_FULL   = 3'd1,
    KIND_WAIT   = 3'd2,
    KIND_CHAIN  = 3'd3,
    KIND_REPEAT = 3'd4,
    KIND_NONE   = 3'd5
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  // One table entry
  typedef struct packed {
    logic [15:0] key;
    logic [1:0]  mode;
    logic [15:0] period;
    logic [15:0] remaining;
    logic [15:0] user_tag;
    logic [7:0]  owner_tag;
    logic [7:0]  chain_target;
  } entry_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [15:0] key;
    logic [15:0] user_tag;
    logic [7:0]  chain_target;
    logic        last;
  } res_t;

  // Operation context handed to the entry unit
  typedef struct packed {
    op_t         op;
    logic [15:0] key;
    logic [1:0]  mode;
    logic [7:0]  owner_tag;
    logic        found;
  } ctrl_t;

  // Verdict of the entry unit on one entry
  typedef struct packed {
    logic keep;
    logic hit;
    logic fire;
    res_t res;
  } verdict_t;

endpackage

`default_nettype wire

>>> design/multi_timer_table.sv
// ----------------------------------------------------------------------------
// multi_timer_table: ordered table of software timers
// Add, clear, dispose-by-owner and tick operations on up to MAX_ENTRIES
// timers, walked one entry per unstalled cycle through a shared entry unit.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on item_valid/item_stall; one transfer takes place when
//   item_valid is high and item_stall low. Results leave on
//   result_valid/result_stall the same way, with last set on the final
//   result of an item.
//   Every item walks the stored entries once, one entry per cycle unless
//   the walk is held, through the shared entry unit, rewriting kept
//   entries in order. item_stall is high for the whole walk.
//   A tick gives one result per firing entry, else one result of kind
//   "nothing fired"; every other item gives exactly one result.
//   A result waits in an output register, so the next item is taken while
//   the receiver stalls. A stalled receiver holds the walk only when a
//   second firing needs the output register.
//   Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_timer_table #(
  parameter int MAX_ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        item_valid,
  output logic             item_stall,
  input  wire logic [1:0]  op,
  input  wire logic [15:0] key,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] period,
  input  wire logic [15:0] user_tag,
  input  wire logic [7:0]  owner_tag,
  input  wire logic [7:0]  chain_target,
  output logic             result_valid,
  input  wire logic        result_stall,
  output logic [2:0]       kind,
  output logic [15:0]      fired_key,
  output logic [15:0]      fired_user_tag,
  output logic [7:0]       fired_chain_target,
  output logic             last
);
  import mtt_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_ENTRIES);

  state_t state, state_next;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] rd_idx;
  logic [CNT_W-1:0] wr_idx;
  logic             rd_vld;
  logic             found;
  logic             pend_valid;
  res_t             pend;
  res_t             out_res;

  // Captured item
  op_t         cur_op;
  logic [15:0] cur_key;
  logic [1:0]  cur_mode;
  logic [15:0] cur_period;
  logic [15:0] cur_user_tag;
  logic [7:0]  cur_owner_tag;
  logic [7:0]  cur_chain_target;

  // Control from the output decode
  logic       accept;
  logic       out_free;
  logic       hold;
  logic       issue;
  logic       proc;
  logic       walk_done;
  logic       finish_go;
  logic       append;
  logic       mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t     mem_wr_data;
  res_t       final_res;

  entry_t   rd_data;
  entry_t   alu_entry;
  ctrl_t    alu_ctrl;
  verdict_t verdict;
  entry_t   new_entry;

  // Entry store
  mtt_table #(
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (issue),
    .rd_addr (rd_idx[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Shared entry unit
  assign alu_ctrl.op        = cur_op;
  assign alu_ctrl.key       = cur_key;
  assign alu_ctrl.mode      = cur_mode;
  assign alu_ctrl.owner_tag = cur_owner_tag;
  assign alu_ctrl.found     = found;

  mtt_entry_alu u_alu (
    .entry_in  (rd_data),
    .ctrl      (alu_ctrl),
    .entry_out (alu_entry),
    .verdict   (verdict)
  );

  // Build the appended entry with the period clamped to at least one
  always_comb begin
    new_entry.key          = cur_key;
    new_entry.mode         = cur_mode;
    new_entry.period       = (cur_period == 16'd0) ? 16'd1 : cur_period;
    new_entry.remaining    = new_entry.period;
    new_entry.user_tag     = cur_user_tag;
    new_entry.owner_tag    = cur_owner_tag;
    new_entry.chain_target = cur_chain_target;
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid) begin
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output decode
  always_comb begin
    item_stall = (state != ST_IDLE);
    accept     = (state == ST_IDLE) && item_valid;
    out_free   = !result_valid || !result_stall;
    hold       = rd_vld && verdict.fire && pend_valid && !out_free;
    issue      = (state == ST_WALK) && !hold && (rd_idx < count);
    proc       = (state == ST_WALK) && rd_vld && !hold;
    walk_done  = (state == ST_WALK) && !rd_vld && (rd_idx >= count);
    finish_go  = (state == ST_FINISH) && out_free;
    append     = finish_go && (cur_op == OP_ADD) && (count < CNT_MAX);

    mem_wr_en   = (proc && verdict.keep) || append;
    mem_wr_addr = (state == ST_FINISH) ? count[IDX_W-1:0] : wr_idx[IDX_W-1:0];
    mem_wr_data = (state == ST_FINISH) ? new_entry : alu_entry;

    final_res      = '0;
    final_res.kind = KIND_DONE;
    final_res.last = 1'b1;
    case (cur_op)
      OP_ADD: begin
        if (count >= CNT_MAX) begin
          final_res.kind = KIND_FULL;
        end
      end
      OP_TICK: begin
        if (pend_valid) begin
          final_res      = pend;
          final_res.last = 1'b1;
        end else begin
          final_res.kind = KIND_NONE;
        end
      end
      default: begin
        final_res.kind = KIND_DONE;
      end
    endcase
  end

  // Sequencer state and table fill
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      if (walk_done) begin
        count <= wr_idx;
      end else if (append) begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // Walk pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      wr_idx <= '0;
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else if (accept) begin
      rd_idx <= '0;
      wr_idx <= '0;
      rd_vld <= 1'b0;
      found  <= 1'b0;
    end else if (state == ST_WALK && !hold) begin
      rd_vld <= issue;
      if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (proc && verdict.keep) begin
        wr_idx <= wr_idx + CNT_W'(1);
      end
      if (proc && verdict.hit) begin
        found <= 1'b1;
      end
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op           <= op_t'(op);
      cur_key          <= key;
      cur_mode         <= mode;
      cur_period       <= period;
      cur_user_tag     <= user_tag;
      cur_owner_tag    <= owner_tag;
      cur_chain_target <= chain_target;
    end
  end

  // Hold the latest firing until the next one or the end of the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (proc && verdict.fire) begin
      pend_valid <= 1'b1;
    end else if (finish_go) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && verdict.fire) begin
      pend <= verdict.res;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((proc && verdict.fire && pend_valid) || finish_go) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && verdict.fire && pend_valid) begin
      out_res <= '{kind: pend.kind, key: pend.key, user_tag: pend.user_tag,
                   chain_target: pend.chain_target, last: 1'b0};
    end else if (finish_go) begin
      out_res <= final_res;
    end
  end

  assign kind               = out_res.kind;
  assign fired_key          = out_res.key;
  assign fired_user_tag     = out_res.user_tag;
  assign fired_chain_target = out_res.chain_target;
  assign last               = out_res.last;

endmodule

`default_nettype wire

>>> design/mtt_table.sv
// ----------------------------------------------------------------------------
// mtt_table: entry store of the timer table
// One write port and one read port; read data is registered and held
// while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_table #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6
) (
  input  wire logic                clk,
  input  wire logic                wr_en,
  input  wire logic [ADDR_W-1:0]   wr_addr,
  input  wire mtt_pkg::entry_t     wr_data,
  input  wire logic                rd_en,
  input  wire logic [ADDR_W-1:0]   rd_addr,
  output mtt_pkg::entry_t          rd_data
);
  import mtt_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> design/mtt_entry_alu.sv
// ----------------------------------------------------------------------------
// mtt_entry_alu: shared per-entry unit
// Matches, counts down and judges one entry per cycle for every operation:
// whether it stays in the table, its new contents and any firing result.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_entry_alu (
  input  wire mtt_pkg::entry_t   entry_in,
  input  wire mtt_pkg::ctrl_t    ctrl,
  output mtt_pkg::entry_t        entry_out,
  output mtt_pkg::verdict_t      verdict
);
  import mtt_pkg::*;

  logic        gone;
  logic [15:0] dec;

  assign gone = (entry_in.mode == MODE_GONE);
  assign dec  = entry_in.remaining - 16'd1;

  always_comb begin
    entry_out        = entry_in;
    verdict.keep     = 1'b1;
    verdict.hit      = 1'b0;
    verdict.fire     = 1'b0;
    verdict.res      = '0;
    verdict.res.kind = KIND_DONE;
    case (ctrl.op)
      // Mark the first entry with this key and mode as disposed
      OP_ADD, OP_CLEAR: begin
        if (!ctrl.found && entry_in.key == ctrl.key && entry_in.mode == ctrl.mode) begin
          verdict.hit    = 1'b1;
          entry_out.mode = MODE_GONE;
        end
      end
      // Drop every entry of this owner
      OP_DROP: begin
        verdict.keep = (entry_in.owner_tag != ctrl.owner_tag);
      end
      // Count down live entries; at zero fire, reload repeats, drop the rest
      OP_TICK: begin
        if (gone) begin
          verdict.keep = 1'b0;
        end else if (dec == 16'd0) begin
          verdict.fire        = 1'b1;
          entry_out.remaining = entry_in.period;
          verdict.res.key     = entry_in.key;
          case (entry_in.mode)
            MODE_SINGLE: begin
              verdict.keep         = 1'b0;
              verdict.res.kind     = KIND_WAIT;
              verdict.res.user_tag = entry_in.user_tag;
            end
            MODE_CHAIN: begin
              verdict.keep             = 1'b0;
              verdict.res.kind         = KIND_CHAIN;
              verdict.res.chain_target = entry_in.chain_target;
            end
            default: begin
              verdict.res.kind     = KIND_REPEAT;
              verdict.res.user_tag = entry_in.user_tag;
            end
          endcase
        end else begin
          entry_out.remaining = dec;
        end
      end
      default: begin
        verdict.keep = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> design/mtt_checker.sv
// ----------------------------------------------------------------------------
// mtt_checker: port checks of the timer table
// Watches the result channel for handshake holding and consistent result
// contents, and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mtt_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        result_valid,
  input wire logic        result_stall,
  input wire logic [2:0]  kind,
  input wire logic [15:0] fired_user_tag,
  input wire logic [7:0]  fired_chain_target,
  input wire logic        last
);
  import mtt_pkg::*;

  // A stalled result stays in place
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(kind) && $stable(last))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Single-result items always close their item
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_DONE || kind == KIND_FULL || kind == KIND_NONE) |-> last)
    else $error("non-firing result without last");

  // Wait and repeat firings carry no chain target, chain firings no user tag
  a_fire_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && (kind == KIND_WAIT || kind == KIND_REPEAT || kind == KIND_CHAIN)
    |-> (kind == KIND_CHAIN) ? (fired_user_tag == 16'd0) : (fired_chain_target == 8'd0))
    else $error("firing result fields inconsistent");

  // Only defined kinds appear
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> kind <= KIND_NONE)
    else $error("undefined result kind");

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
  .clk                (clk),
  .rst                (rst),
  .result_valid       (result_valid),
  .result_stall       (result_stall),
  .kind               (kind),
  .fired_user_tag     (fired_user_tag),
  .fired_chain_target (fired_chain_target),
  .last               (last)
);

`default_nettype wire
